@@ rtl/core/vds_pkg.sv @@
// vds_pkg: shared types and constants of the vector distance and similarity unit
`timescale 1ns / 1ps
`default_nettype none
package vds_pkg;

  localparam int ElemWidth = 16;
  localparam int AccWidth  = 48;
  localparam int OutFrac   = 24;

  localparam logic signed [AccWidth-1:0] AccMax = {1'b0, {(AccWidth-1){1'b1}}};
  localparam logic signed [AccWidth-1:0] AccMin = {1'b1, {(AccWidth-1){1'b0}}};

  // metric codes
  localparam logic [1:0] METRIC_COSINE = 2'd0;
  localparam logic [1:0] METRIC_L2     = 2'd1;
  localparam logic [1:0] METRIC_INNER  = 2'd2;

  // status codes
  localparam logic [1:0] STATUS_OK   = 2'd0;
  localparam logic [1:0] STATUS_ZERO = 2'd1;
  localparam logic [1:0] STATUS_SAT  = 2'd2;

  typedef struct packed {
    logic signed [ElemWidth-1:0] a_elem;
    logic signed [ElemWidth-1:0] b_elem;
    logic                        last;
  } item_t;

  typedef struct packed {
    logic signed [AccWidth-1:0] distance;
    logic signed [AccWidth-1:0] similarity;
    logic [1:0]                 status;
  } result_t;

  // sums of one finished vector pair, handed from front to back
  typedef struct packed {
    logic signed [AccWidth-1:0] dot_sum;
    logic signed [AccWidth-1:0] norm_a_sum;
    logic signed [AccWidth-1:0] norm_b_sum;
    logic signed [AccWidth-1:0] diff_sq_sum;
    logic                       acc_ovf;
    logic [1:0]                 metric;
  } sums_t;

  // queue fill signals seen by the front
  typedef struct packed {
    logic empty;
    logic nearly_full;
  } qstat_t;

  // clamp a 52-bit signed value to 48 bits
  function automatic logic signed [AccWidth-1:0] sat48(input logic signed [51:0] x);
    logic signed [AccWidth-1:0] r;
    if (x > 52'(AccMax)) r = AccMax;
    else if (x < 52'(AccMin)) r = AccMin;
    else r = x[AccWidth-1:0];
    return r;
  endfunction

  function automatic logic is_sat48(input logic signed [51:0] x);
    return (x > 52'(AccMax)) || (x < 52'(AccMin));
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/vds_front.sv @@
// vds_front: product stage and saturating accumulators, hands sums to the queue on last
`timescale 1ns / 1ps
`default_nettype none
module vds_front (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 item_valid,
  output logic                item_stall,
  input  vds_pkg::item_t      item,
  input  wire  [1:0]          metric,
  input  vds_pkg::qstat_t     qstat,
  output logic                push,
  output vds_pkg::sums_t      push_data
);
  import vds_pkg::*;

  logic                       p_valid;
  logic                       p_last;
  logic signed [31:0]         p_ab, p_aa, p_bb;
  logic [33:0]                p_dsq;
  logic signed [AccWidth-1:0] dot_sum, norm_a_sum, norm_b_sum, diff_sq_sum;
  logic                       acc_ovf;
  logic signed [AccWidth-1:0] dot_next, na_next, nb_next, dsq_next;
  logic                       ovf_next;
  logic signed [16:0]         diff;
  logic                       accept;

  assign item_stall = qstat.nearly_full;
  assign accept     = item_valid && !item_stall;
  assign diff       = 17'(item.a_elem) - 17'(item.b_elem);

  // saturating add of one term onto a sum
  function automatic logic signed [AccWidth:0] sadd(input logic signed [AccWidth-1:0] acc,
                                                    input logic signed [AccWidth-1:0] t);
    logic signed [AccWidth:0] s;
    s = {acc[AccWidth-1], acc} + {t[AccWidth-1], t};
    if (s[AccWidth] != s[AccWidth-1])
      return {1'b1, (s[AccWidth] ? AccMin : AccMax)};
    return {1'b0, s[AccWidth-1:0]};
  endfunction

  // products of the accepted pair
  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else begin
      p_valid <= accept;
    end
    p_last <= item.last;
    p_ab   <= item.a_elem * item.b_elem;
    p_aa   <= item.a_elem * item.a_elem;
    p_bb   <= item.b_elem * item.b_elem;
    p_dsq  <= 34'(diff * diff);
  end

  // next sums
  always_comb begin
    logic [AccWidth:0] r0, r1, r2, r3;
    r0 = sadd(dot_sum,     48'(p_ab));
    r1 = sadd(norm_a_sum,  48'(p_aa));
    r2 = sadd(norm_b_sum,  48'(p_bb));
    r3 = sadd(diff_sq_sum, {14'd0, p_dsq});
    dot_next = r0[AccWidth-1:0];
    na_next  = r1[AccWidth-1:0];
    nb_next  = r2[AccWidth-1:0];
    dsq_next = r3[AccWidth-1:0];
    ovf_next = acc_ovf | r0[AccWidth] | r1[AccWidth] | r2[AccWidth] | r3[AccWidth];
  end

  assign push = p_valid && p_last;
  assign push_data = '{dot_sum: dot_next, norm_a_sum: na_next, norm_b_sum: nb_next,
                       diff_sq_sum: dsq_next, acc_ovf: ovf_next, metric: metric};

  // accumulators, cleared once the sums are handed on
  always_ff @(posedge clk) begin
    if (rst || push) begin
      dot_sum     <= '0;
      norm_a_sum  <= '0;
      norm_b_sum  <= '0;
      diff_sq_sum <= '0;
      acc_ovf     <= 1'b0;
    end else if (p_valid) begin
      dot_sum     <= dot_next;
      norm_a_sum  <= na_next;
      norm_b_sum  <= nb_next;
      diff_sq_sum <= dsq_next;
      acc_ovf     <= ovf_next;
    end
  end

endmodule
`default_nettype wire

@@ rtl/core/vds_queue.sv @@
// vds_queue: short queue of finished sums between front and back
`timescale 1ns / 1ps
`default_nettype none
module vds_queue (
  input  wire              clk,
  input  wire              rst,
  input  wire              push,
  input  vds_pkg::sums_t   push_data,
  input  wire              pop,
  output vds_pkg::sums_t   head,
  output vds_pkg::qstat_t  qstat
);
  import vds_pkg::*;

  localparam int Depth = 4;

  sums_t      entries [Depth];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign head              = entries[rd_ptr];
  assign qstat.empty       = (count == 3'd0);
  // one slot kept for a beat still in the product stage
  assign qstat.nearly_full = (count >= 3'(Depth - 1));

  always_ff @(posedge clk) begin
    if (push) entries[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 2'd1;
      if (pop)  rd_ptr <= rd_ptr + 2'd1;
      count <= count + 3'(push) - 3'(pop);
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    !(push && count == 3'(Depth) && !pop)) else $error("queue overflow");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    !(pop && count == 3'd0)) else $error("queue underflow");
  a_count_up: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> count == $past(count) + 3'd1) else $error("count slip");
`endif

endmodule
`default_nettype wire

@@ rtl/core/vds_back.sv @@
// vds_back: sequential multiply, square root and divide that turn sums into a result
`timescale 1ns / 1ps
`default_nettype none
module vds_back (
  input  wire              clk,
  input  wire              rst,
  input  wire              q_empty,
  input  vds_pkg::sums_t   head,
  output logic             pop,
  output logic             result_valid,
  input  wire              result_stall,
  output vds_pkg::result_t result
);
  import vds_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MUL, S_SQRT, S_DIV, S_FIN, S_DONE} state_t;

  state_t                     state;
  sums_t                      job;
  logic [6:0]                 cnt;
  logic [95:0]                mul_a, acc;
  logic [47:0]                mul_b;
  logic [95:0]                rad;
  logic [49:0]                srem;
  logic [47:0]                root;
  logic [71:0]                dvd, quo;
  logic [47:0]                dvs;
  logic [48:0]                drem;
  result_t                    res;

  logic [51:0]                srem_sh, strial;
  logic [48:0]                drem_sh;
  logic [95:0]                acc_add;
  logic [47:0]                dot_mag;
  logic                       zero_norm;
  result_t                    fin;

  assign pop       = (state == S_IDLE) && !q_empty;
  assign zero_norm = head.norm_a_sum[47] || (head.norm_a_sum == '0) ||
                     head.norm_b_sum[47] || (head.norm_b_sum == '0);
  assign acc_add   = mul_b[0] ? acc + mul_a : acc;
  assign srem_sh   = {srem, rad[95:94]};
  assign strial    = {2'b00, root, 2'b01};
  assign drem_sh   = {drem[47:0], dvd[71]};
  assign dot_mag   = job.dot_sum[47] ? 48'(-job.dot_sum) : job.dot_sum;

  // result of a cosine or L2 job from quotient and root
  always_comb begin
    logic signed [51:0] c, d;
    logic               neg;
    neg = job.dot_sum[47];
    fin = '{distance: '0, similarity: '0, status: STATUS_OK};
    c = '0;
    d = '0;
    if (job.metric == METRIC_L2) begin
      fin.distance   = root;
      fin.similarity = quo[47:0];
    end else if (quo[71:48] != '0) begin
      fin.similarity = neg ? AccMin : AccMax;
      fin.distance   = neg ? AccMax : AccMin;
      fin.status     = STATUS_SAT;
    end else begin
      c = neg ? -52'(quo[47:0]) : 52'(quo[47:0]);
      d = (52'sd1 <<< OutFrac) - c;
      fin.similarity = sat48(c);
      fin.distance   = sat48(d);
      if (is_sat48(c) || is_sat48(d)) fin.status = STATUS_SAT;
    end
    if (fin.status == STATUS_OK && job.acc_ovf) fin.status = STATUS_SAT;
  end

  // sequencer with output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && state != S_DONE) result_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (!q_empty) begin
            job <= head;
            case (head.metric)
              METRIC_COSINE: begin
                if (zero_norm) begin
                  res   <= '{distance: AccMax, similarity: AccMax, status: STATUS_ZERO};
                  state <= S_DONE;
                end else begin
                  mul_a <= {48'd0, head.norm_a_sum};
                  mul_b <= head.norm_b_sum;
                  acc   <= '0;
                  cnt   <= 7'd48;
                  state <= S_MUL;
                end
              end
              METRIC_L2: begin
                rad   <= head.diff_sq_sum[47] ? '0 : {24'd0, head.diff_sq_sum, 24'd0};
                srem  <= '0;
                root  <= '0;
                cnt   <= 7'd48;
                state <= S_SQRT;
              end
              METRIC_INNER: begin
                res.similarity <= head.dot_sum;
                res.distance   <= sat48(-52'(head.dot_sum));
                res.status     <= (head.dot_sum == AccMin || head.acc_ovf) ?
                                  STATUS_SAT : STATUS_OK;
                state          <= S_DONE;
              end
              default: begin
                res   <= '{distance: AccMax, similarity: '0, status: STATUS_SAT};
                state <= S_DONE;
              end
            endcase
          end
        end
        S_MUL: begin
          acc   <= acc_add;
          mul_a <= mul_a << 1;
          mul_b <= mul_b >> 1;
          cnt   <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            rad   <= acc_add;
            srem  <= '0;
            root  <= '0;
            cnt   <= 7'd48;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          rad <= rad << 2;
          if (srem_sh >= strial) begin
            srem <= 50'(srem_sh - strial);
            root <= {root[46:0], 1'b1};
          end else begin
            srem <= srem_sh[49:0];
            root <= {root[46:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) begin
            state <= S_DIV;
            cnt   <= 7'd72;
            drem  <= '0;
            quo   <= '0;
            // divider operands, taken from the root as it completes
            if (job.metric == METRIC_L2) begin
              dvd <= 72'd1 << (2 * OutFrac);
              dvs <= (48'd1 << OutFrac) + {root[46:0], (srem_sh >= strial)};
            end else begin
              dvd <= {dot_mag, 24'd0};
              dvs <= {root[46:0], (srem_sh >= strial)};
            end
          end
        end
        S_DIV: begin
          dvd <= dvd << 1;
          if (drem_sh >= {1'b0, dvs}) begin
            drem <= drem_sh - {1'b0, dvs};
            quo  <= {quo[70:0], 1'b1};
          end else begin
            drem <= drem_sh;
            quo  <= {quo[70:0], 1'b0};
          end
          cnt <= cnt - 7'd1;
          if (cnt == 7'd1) state <= S_FIN;
        end
        S_FIN: begin
          res   <= fin;
          state <= S_DONE;
        end
        S_DONE: begin
          if (!result_valid || !result_stall) begin
            result       <= res;
            result_valid <= 1'b1;
            state        <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

`ifndef SYNTHESIS
  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |=> state != S_IDLE) else $error("pop without leaving idle");
  a_div_nonzero: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> dvs != '0) else $error("divide by zero");
  a_load_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && !(result_valid && result_stall)) |=> result_valid)
    else $error("result not loaded");
`endif

endmodule
`default_nettype wire

@@ rtl/core/vector_distance_and_similarity_unit.sv @@
// vector_distance_and_similarity_unit: top level of the streaming distance unit
//
//  channel   dir  handshake                 beat
//  item      in   item_valid / item_stall   a_elem, b_elem, last
//  result    out  result_valid/result_stall distance, similarity, status
//  cfg       in   cfg_valid / cfg_ready     metric_select
//
// element pairs are taken one a cycle while item_stall is low; the product stage
// and accumulators never stall; the back runs multiply, root and divide steps under
// cosine, root and divide steps under L2 and none under inner product
// a four-entry queue of finished sums lets pairs keep flowing while the back works;
// item_stall rises only when that queue is nearly full
// rst is synchronous; it clears sums, queue, sequencer and metric_select to cosine
`timescale 1ns / 1ps
`default_nettype none
module vector_distance_and_similarity_unit (
  input  wire              clk,
  input  wire              rst,
  input  wire              item_valid,
  output logic             item_stall,
  input  vds_pkg::item_t   item,
  output logic             result_valid,
  input  wire              result_stall,
  output vds_pkg::result_t result,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [1:0]       cfg_data
);
  import vds_pkg::*;

  logic [1:0] metric_select;
  logic       push, pop;
  sums_t      push_data, head;
  qstat_t     qstat;

  assign cfg_ready = 1'b1;

  // metric register
  always_ff @(posedge clk) begin
    if (rst) begin
      metric_select <= METRIC_COSINE;
    end else if (cfg_valid && cfg_ready) begin
      metric_select <= cfg_data;
    end
  end

  vds_front u_front (
    .clk, .rst, .item_valid, .item_stall, .item,
    .metric(metric_select), .qstat, .push, .push_data
  );

  vds_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .qstat
  );

  vds_back u_back (
    .clk, .rst, .q_empty(qstat.empty), .head, .pop,
    .result_valid, .result_stall, .result
  );

endmodule
`default_nettype wire
